// ===== design/binomial_coefficient_assert.svh =====
// Assertion macros shared by the binomial coefficient block.
// Included by the top level; depends on nothing else.
`ifndef BINOMIAL_COEFFICIENT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCF_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("binomial_coefficient: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BCF_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("binomial_coefficient: next-cycle check failed");

`endif

// ===== design/bcf_pkg.sv =====
// Shared widths, limits and control types of the binomial coefficient block.
// Used by all modules of the block; depends on nothing.
package bcf_pkg;

   localparam int N_W    = 6;
   localparam int COEF_W = 59;
   localparam int PROD_W = 64;
   localparam int CNT_W  = $clog2(PROD_W);

   localparam logic [N_W-1:0]    MAX_SET_SIZE = N_W'(62);
   localparam logic [COEF_W-1:0] COEF_SAT     = '1;
   localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(PROD_W - 1);

   // Sequencing for one serial pass of a digit cell.
   typedef struct packed {
      logic first;    // first bit of the pass: ignore the stored carry or remainder
      logic advance;  // a bit moves through the cell this cycle
   } bcf_step_ctl_type;

endpackage

// ===== design/bcf_mul_digit.sv =====
// Bit-serial multiply of a word, taken LSB first, by a narrow factor.
// Depends on bcf_pkg.
module bcf_mul_digit (
   input  logic                          clock,
   input  bcf_pkg::bcf_step_ctl_type     ctl,
   input  logic [bcf_pkg::N_W-1:0]       factor,
   input  logic                          in_bit,
   output logic                          out_bit
);
   import bcf_pkg::*;

   logic [N_W-1:0] carry_ff;
   logic [N_W-1:0] carry_in;
   logic [N_W-1:0] carry_use;
   logic [N_W:0]   sum;

   // The carry stays below the factor, so sum fits in one extra bit.
   always_comb begin
      carry_use = ctl.first ? '0 : carry_ff;
      sum       = {1'b0, carry_use} + (in_bit ? {1'b0, factor} : '0);
      out_bit   = sum[0];
      carry_in  = sum[N_W:1];
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== design/bcf_div_digit.sv =====
// Restoring division of a word, taken MSB first, by a narrow divisor.
// Emits one quotient bit per cycle while ctl.advance is set. Depends on bcf_pkg.
module bcf_div_digit (
   input  logic                          clock,
   input  bcf_pkg::bcf_step_ctl_type     ctl,
   input  logic [bcf_pkg::N_W-1:0]       divisor,
   input  logic                          in_bit,
   output logic                          out_bit
);
   import bcf_pkg::*;

   logic [N_W-1:0] rem_ff;
   logic [N_W-1:0] rem_in;
   logic [N_W-1:0] rem_use;
   logic [N_W:0]   shifted;
   logic [N_W:0]   diff;

   // The remainder stays below the divisor, so shifted is below twice it.
   always_comb begin
      rem_use = ctl.first ? '0 : rem_ff;
      shifted = {rem_use, in_bit};
      diff    = shifted - {1'b0, divisor};
      out_bit = (shifted >= {1'b0, divisor});
      rem_in  = out_bit ? diff[N_W-1:0] : shifted[N_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== design/binomial_coefficient.sv =====
// Binomial coefficient C(n,k): control sequencer and the 64-bit work register.
// Depends on bcf_pkg, bcf_mul_digit, bcf_div_digit and the assertion header.
//
// Usage: drive req_set_size (n) and req_choose_count (k) and raise start while
// busy is low; the item is taken at that clock edge. One result follows on
// rsp_coefficient, marked by rsp_valid for exactly one cycle.
// n above 62 gives all ones; k = 0 or k = n gives 1; k > n gives 0. These
// trivial items answer in the cycle after acceptance and never raise busy.
// Otherwise the block runs m = min(k, n-k) terms of C = C*(n-i)/(i+1).
// Each term passes the 64-bit work register twice through one-bit cells:
// first through the serial multiplier, then through the serial divider.
// busy stays high while the terms run, and the next item may start in the
// cycle that carries the result. One item is in work at a time.
// Synchronous reset returns the sequencer to idle and drops rsp_valid.
// The receiver cannot stall: each result is taken in its strobe cycle.
`include "binomial_coefficient_assert.svh"

module binomial_coefficient (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bcf_pkg::N_W-1:0]      req_set_size,
   input  logic [bcf_pkg::N_W-1:0]      req_choose_count,
   output logic                         rsp_valid,
   output logic [bcf_pkg::COEF_W-1:0]   rsp_coefficient
);
   import bcf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_DIV  = 3'b100
   } bcf_state_type;

   bcf_state_type     state_ff, state_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [N_W-1:0]    m_ff, m_in;
   logic [N_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] work_ff, work_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0] coef_ff, coef_in;

   logic              accept;
   logic [N_W-1:0]    n_minus_k;
   logic [N_W-1:0]    factor;
   logic [N_W-1:0]    divisor;
   logic [N_W-1:0]    i_next;
   logic              last_bit;
   logic              mul_bit;
   logic              div_bit;
   bcf_step_ctl_type  mul_ctl;
   bcf_step_ctl_type  div_ctl;

   assign accept    = start && (state_ff == ST_IDLE);
   assign n_minus_k = req_set_size - req_choose_count;
   assign factor    = n_ff - i_ff;
   assign i_next    = i_ff + N_W'(1);
   assign divisor   = i_next;
   assign last_bit  = (cnt_ff == CNT_LAST);

   assign mul_ctl.first   = (cnt_ff == '0);
   assign mul_ctl.advance = (state_ff == ST_MUL);
   assign div_ctl.first   = (cnt_ff == '0);
   assign div_ctl.advance = (state_ff == ST_DIV);

   bcf_mul_digit u_mul (
      .clock   (clock),
      .ctl     (mul_ctl),
      .factor  (factor),
      .in_bit  (work_ff[0]),
      .out_bit (mul_bit)
   );

   bcf_div_digit u_div (
      .clock   (clock),
      .ctl     (div_ctl),
      .divisor (divisor),
      .in_bit  (work_ff[PROD_W-1]),
      .out_bit (div_bit)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      cnt_in       = cnt_ff;
      work_in      = work_ff;
      rsp_valid_in = 1'b0;
      coef_in      = coef_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in    = req_set_size;
               m_in    = (req_choose_count < n_minus_k) ? req_choose_count : n_minus_k;
               i_in    = '0;
               cnt_in  = '0;
               work_in = PROD_W'(1);
               if (req_set_size > MAX_SET_SIZE) begin
                  rsp_valid_in = 1'b1;
                  coef_in      = COEF_SAT;
               end else if (req_choose_count == '0 || req_choose_count == req_set_size) begin
                  rsp_valid_in = 1'b1;
                  coef_in      = COEF_W'(1);
               end else if (req_choose_count > req_set_size) begin
                  rsp_valid_in = 1'b1;
                  coef_in      = '0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // Product bits arrive LSB first at the top while C leaves the bottom.
            work_in = {mul_bit, work_ff[PROD_W-1:1]};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Dividend bits leave the top while quotient bits enter the bottom.
            work_in = {work_ff[PROD_W-2:0], div_bit};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               i_in = i_next;
               if (i_next == m_ff) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  coef_in      = work_in[COEF_W-1:0];
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      m_ff    <= m_in;
      i_ff    <= i_in;
      work_ff <= work_in;
      coef_ff <= coef_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = coef_ff;

   // An accepted item either answers at once or starts the serial sequence.
   `BCF_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)
   // A result is only issued once the sequencer has let go of the item.
   `BCF_ASSERT_NOW(a_valid_not_busy, clock, reset, rsp_valid, !busy)
   // A finished multiply pass always hands over to the divide pass.
   `BCF_ASSERT_NEXT(a_mul_to_div, clock, reset, state_ff == ST_MUL && last_bit,
                    state_ff == ST_DIV)

endmodule
